>>> design/wkalrm_pkg.sv
// Shared types and constants for the weekly alarm next-time unit.
// No dependencies; used by wkalrm_calc and weekly_alarm_next_time_unit.
package wkalrm_pkg;

    localparam int unsigned IN_W  = 64;
    localparam int unsigned OUT_W = 40;

    localparam logic [31:0] SECS_MINUTE = 32'd60;
    localparam logic [31:0] SECS_HOUR   = 32'd3600;
    localparam logic [31:0] SECS_DAY    = 32'd86400;
    localparam logic [31:0] SECS_YEAR   = 32'd31536000;
    localparam logic [15:0] EPOCH_YEAR  = 16'd1970;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    // Input word, first field in the highest bits.
    typedef struct packed {
        logic        include_today;
        logic [5:0]  now_minute;
        logic [4:0]  now_hour;
        logic [2:0]  now_weekday;
        logic [4:0]  now_day;
        logic [3:0]  now_month;
        logic [11:0] now_year;
        logic [5:0]  alarm_second;
        logic [5:0]  alarm_minute;
        logic [4:0]  alarm_hour;
        logic [6:0]  weekday_mask;
        logic [3:0]  task_slot;
    } in_item_t;

    // Result word, first field in the highest bits.
    typedef struct packed {
        logic [31:0] alarm_seconds;
        logic [2:0]  days_ahead;
        logic        found;
        logic [3:0]  result_slot;
    } res_t;

    // Days before the first of month; index is month - 1.
    function automatic logic [8:0] days_before_month(input logic [3:0] idx);
        logic [8:0] d;
        case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

>>> design/wkalrm_calc.sv
// Combinational next-run calculation: weekday pick and Unix seconds.
// Depends on wkalrm_pkg.
module wkalrm_calc (
    input  wkalrm_pkg::in_item_t item,
    output wkalrm_pkg::res_t     res
);

    logic        slot_passed;
    logic        today_ok;
    logic [7:0]  day_hit;
    logic        hit;
    logic [2:0]  ahead;
    logic [15:0] yrs;
    logic [16:0] yrs_p1;
    logic [3:0]  month_cl;
    logic        leap_add;
    logic [31:0] day_count;
    logic [31:0] secs;
    logic [3:0]  wd_sum;
    logic [2:0]  wd_idx;

    // Slot already gone today: seconds are not compared
    assign slot_passed = (item.alarm_hour < item.now_hour) ||
                         ((item.alarm_hour == item.now_hour) &&
                          (item.alarm_minute < item.now_minute));
    assign today_ok = item.include_today && !slot_passed;

    // Enabled flag per offset 0..7
    always_comb begin
        for (int d = 0; d < 8; d++) begin
            wd_sum = 4'(item.now_weekday) - 4'd1 + 4'(d);
            wd_idx = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[2:0];
            if (item.now_weekday == 3'd0) begin
                // weekday zero: first day matches nothing, then Monday on
                // (wd_idx is d - 1 here for d above zero)
                day_hit[d] = (d == 0) ? 1'b0 : item.weekday_mask[wd_idx];
            end else begin
                day_hit[d] = item.weekday_mask[wd_idx];
            end
        end
        day_hit[0] = day_hit[0] && today_ok;
    end

    // Lowest enabled offset wins
    always_comb begin
        hit   = 1'b0;
        ahead = 3'd0;
        for (int d = 7; d >= 0; d--) begin
            if (day_hit[d]) begin
                hit   = 1'b1;
                ahead = 3'(d);
            end
        end
    end

    // Date to Unix seconds, four-year leap rule
    assign yrs      = 16'(item.now_year) - wkalrm_pkg::EPOCH_YEAR;
    assign yrs_p1   = 17'(yrs) + 17'd1;
    assign month_cl = (item.now_month < wkalrm_pkg::MONTH_JAN) ? wkalrm_pkg::MONTH_JAN :
                      (item.now_month > wkalrm_pkg::MONTH_DEC) ? wkalrm_pkg::MONTH_DEC :
                      item.now_month;
    assign leap_add = (item.now_month > wkalrm_pkg::MONTH_FEB) && (yrs[1:0] == 2'd2);

    assign day_count = 32'(yrs_p1[16:2])
                     + 32'(wkalrm_pkg::days_before_month(month_cl - 4'd1))
                     + 32'(leap_add)
                     + 32'(item.now_day) + 32'(ahead) - 32'd1;

    assign secs = wkalrm_pkg::SECS_YEAR * 32'(yrs)
                + wkalrm_pkg::SECS_DAY * day_count
                + wkalrm_pkg::SECS_HOUR * 32'(item.alarm_hour)
                + wkalrm_pkg::SECS_MINUTE * 32'(item.alarm_minute)
                + 32'(item.alarm_second);

    assign res.result_slot   = item.task_slot;
    assign res.found         = hit;
    assign res.days_ahead    = ahead;
    assign res.alarm_seconds = hit ? secs : 32'd0;

endmodule

>>> design/weekly_alarm_next_time_unit.sv
// An accepted word is captured in the input register; its result is loaded into the
// result register, which drives m_tdata. Throughput: one word per cycle while
// m_tready does not stall; an input register and a result register
// form a two-stage pipeline, the single-pass date/seconds logic between them.
// A full result register holding a stalled word still lets the input stage
// take a new word while a slot is free in the pipeline.
// Reset: aresetn synchronous, active low; clears both valid flags only.
module weekly_alarm_next_time_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, lowest bit up: task_slot[3:0], weekday_mask[10:4],
    // alarm_hour[15:11], alarm_minute[21:16], alarm_second[27:22],
    // now_year[39:28], now_month[43:40], now_day[48:44],
    // now_weekday[51:49], now_hour[56:52], now_minute[62:57],
    // include_today[63]
    input  logic [wkalrm_pkg::IN_W-1:0]  s_tdata,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, lowest bit up: result_slot[3:0], found[4],
    // days_ahead[7:5], alarm_seconds[39:8]
    output logic [wkalrm_pkg::OUT_W-1:0] m_tdata
);

    // Stage 1: captured input word
    wkalrm_pkg::in_item_t in_item_reg;
    logic                 in_valid_reg;
    logic                 in_valid_next;

    // Stage 2: result word
    wkalrm_pkg::res_t     res_reg;
    wkalrm_pkg::res_t     res_comb;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    logic                 out_load;
    logic                 in_load;

    // Result register takes a new word when empty or being drained
    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    // Input register is free when empty or its word moves on this cycle
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    assign in_valid_next  = in_load ? 1'b1 : (out_load ? 1'b0 : in_valid_reg);
    assign out_valid_next = out_load ? 1'b1 :
                            (m_tready ? 1'b0 : out_valid_reg);

    wkalrm_calc u_calc (
        .item (in_item_reg),
        .res  (res_comb)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_item_reg <= wkalrm_pkg::in_item_t'(s_tdata);
        end
        if (out_load) begin
            res_reg <= res_comb;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = res_reg;

    // Nothing found means zero offset and zero seconds
    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !res_reg.found) |->
            (res_reg.days_ahead == 3'd0 && res_reg.alarm_seconds == 32'd0))
        else $error("not-found word carries non-zero fields");

    // A fresh result only ever comes from a held input word
    a_out_from_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !$past(out_valid_reg && !m_tready)) |->
            $past(in_valid_reg))
        else $error("result appeared without an input word");

    // An empty input stage always accepts
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");

    // A stalled input word is kept until it moves on
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_load) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("input word lost while stalled");

endmodule

>>> verif/weekly_alarm_next_time_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for weekly_alarm_next_time_unit: directed and random words,
// with stalls on both streams, checked against an in-bench next-alarm calculation.
// Depends on wkalrm_pkg (in_item_t, res_t, SECS_* constants) and the unit itself.
module weekly_alarm_next_time_unit_tb;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned RANDOM_WORDS  = 1500;
    localparam int unsigned DRAIN_CYCLES  = 10;   // pipeline is two deep
    localparam int unsigned QUIET_BLOCK   = 250;  // words per idling regime

    // Holds the alarm results still owed by the unit and works each one out
    // from the task word as it is accepted.
    class alarm_check;
        wkalrm_pkg::res_t pending_alarms[$];
        int unsigned      mismatches = 0;
        // Days before the first of each month, non-leap year.
        bit [31:0]   month_start[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                         304, 334};

        function wkalrm_pkg::res_t next_alarm(wkalrm_pkg::in_item_t w);
            bit               today_ok;
            bit               hit;
            bit [31:0]        wd;
            bit [31:0]        ahead;
            bit [31:0]        yrs;
            bit [31:0]        mon;
            bit [31:0]        day_sum;
            bit [31:0]        secs;
            wkalrm_pkg::res_t r;
            today_ok = w.include_today;
            // Slot already gone today: seconds play no part in the comparison.
            if (w.alarm_hour < w.now_hour ||
                (w.alarm_hour == w.now_hour && w.alarm_minute < w.now_minute))
                today_ok = 1'b0;
            wd    = 32'(w.now_weekday);
            hit   = 1'b0;
            ahead = 0;
            secs  = 0;
            // Eight days scanned, so a lone excluded today comes back a week on.
            for (int d = 0; d < 8; d++) begin
                if (wd > 7)
                    wd = 1;
                if (!hit && wd >= 1 && w.weekday_mask[wd - 1] && (d != 0 || today_ok)) begin
                    hit   = 1'b1;
                    ahead = d;
                end
                wd++;
            end
            if (hit) begin
                yrs = (32'(w.now_year) - 32'd1970) & 32'h0000_FFFF;
                mon = 32'(w.now_month);
                if (mon < 1)
                    mon = 1;
                if (mon > 12)
                    mon = 12;
                day_sum = 32'(w.now_day) + ahead;
                secs  = wkalrm_pkg::SECS_YEAR * yrs + wkalrm_pkg::SECS_DAY * ((yrs + 1) / 4);
                secs += wkalrm_pkg::SECS_DAY * month_start[mon - 1];
                // Leap day uses the raw month, so months above twelve get it too.
                if (w.now_month > 2 && (yrs + 2) % 4 == 0)
                    secs += wkalrm_pkg::SECS_DAY;
                secs += wkalrm_pkg::SECS_DAY * (day_sum - 1);
                secs += wkalrm_pkg::SECS_HOUR * 32'(w.alarm_hour)
                        + wkalrm_pkg::SECS_MINUTE * 32'(w.alarm_minute)
                        + 32'(w.alarm_second);
            end
            r.result_slot   = w.task_slot;
            r.found         = hit;
            r.days_ahead    = ahead[2:0];
            r.alarm_seconds = secs;
            return r;
        endfunction

        function void note_task(wkalrm_pkg::in_item_t w);
            pending_alarms.push_back(next_alarm(w));
        endfunction

        function void check_alarm(wkalrm_pkg::res_t got);
            wkalrm_pkg::res_t want;
            if (pending_alarms.size() == 0) begin
                $error("result word with nothing outstanding: %h", got);
                mismatches++;
                return;
            end
            want = pending_alarms.pop_front();
            if (got.result_slot !== want.result_slot) begin
                $error("result_slot: expected %0d, got %0d", want.result_slot, got.result_slot);
                mismatches++;
            end
            if (got.found !== want.found) begin
                $error("found: expected %0d, got %0d", want.found, got.found);
                mismatches++;
            end
            if (got.days_ahead !== want.days_ahead) begin
                $error("days_ahead: expected %0d, got %0d", want.days_ahead, got.days_ahead);
                mismatches++;
            end
            if (got.alarm_seconds !== want.alarm_seconds) begin
                $error("alarm_seconds: expected %0d, got %0d",
                       want.alarm_seconds, got.alarm_seconds);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;   // task_slot, weekday_mask, alarm_hour, alarm_minute,
                                  // alarm_second, now_year, now_month, now_day,
                                  // now_weekday, now_hour, now_minute, include_today
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // result_slot, found, days_ahead, alarm_seconds

    alarm_check  board = new();
    bit          quiet = 1'b0;    // set: neither side inserts gaps
    int unsigned hold_left = 0;
    int unsigned cycles = 0;

    weekly_alarm_next_time_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // Run guard: a hang anywhere ends here.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result side: values seen here are those of the edge itself, so the
    // handshake check and the next tready decision never race the unit.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_alarm(wkalrm_pkg::res_t'(m_tdata));
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < 30)
                hold_left = gap_len();
        end
    end

    function automatic wkalrm_pkg::in_item_t task_word(
        input logic [3:0]  slot,
        input logic [6:0]  mask,
        input logic [4:0]  a_hour,
        input logic [5:0]  a_min,
        input logic [5:0]  a_sec,
        input logic [11:0] year,
        input logic [3:0]  month,
        input logic [4:0]  day,
        input logic [2:0]  wday,
        input logic [4:0]  n_hour,
        input logic [5:0]  n_min,
        input logic        inc_today
    );
        wkalrm_pkg::in_item_t w;
        w.task_slot     = slot;
        w.weekday_mask  = mask;
        w.alarm_hour    = a_hour;
        w.alarm_minute  = a_min;
        w.alarm_second  = a_sec;
        w.now_year      = year;
        w.now_month     = month;
        w.now_day       = day;
        w.now_weekday   = wday;
        w.now_hour      = n_hour;
        w.now_minute    = n_min;
        w.include_today = inc_today;
        return w;
    endfunction

    // Mostly sensible calendar words, biased so today's slot is often on the
    // edge of having passed; a quarter are raw bits to reach every odd case.
    function automatic wkalrm_pkg::in_item_t random_task();
        wkalrm_pkg::in_item_t w;
        int unsigned          pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            return wkalrm_pkg::in_item_t'({$urandom(), $urandom()});
        w.task_slot = 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 10)
            w.weekday_mask = '0;
        else if (pick < 40)
            w.weekday_mask = 7'(1 << $urandom_range(0, 6));
        else
            w.weekday_mask = 7'($urandom_range(0, 127));
        w.alarm_hour    = 5'($urandom_range(0, 23));
        w.alarm_minute  = 6'($urandom_range(0, 59));
        w.alarm_second  = 6'($urandom_range(0, 59));
        w.now_year      = 12'($urandom_range(1970, 2099));
        w.now_month     = 4'($urandom_range(1, 12));
        w.now_day       = 5'($urandom_range(1, 31));
        w.now_weekday   = 3'($urandom_range(1, 7));
        w.now_hour      = ($urandom_range(0, 99) < 40) ? w.alarm_hour : 5'($urandom_range(0, 23));
        pick = $urandom_range(0, 99);
        if (pick < 40)
            w.now_minute = w.alarm_minute + 6'($urandom_range(0, 2)) - 6'd1;
        else
            w.now_minute = 6'($urandom_range(0, 59));
        w.include_today = 1'($urandom_range(0, 1));
        return w;
    endfunction

    // Offer one task word and hold it until the unit takes it. tvalid is only
    // dropped when a gap is wanted, so back-to-back words keep it high.
    task automatic send_task(input wkalrm_pkg::in_item_t w);
        int unsigned gap;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        board.note_task(w);
    endtask

    initial begin
        wkalrm_pkg::in_item_t directed[$];

        // No days enabled at all.
        directed.push_back(task_word(0, 7'h00, 8, 0, 0, 2024, 5, 15, 3, 7, 0, 1));
        // Only today enabled: slot not yet gone, then excluded three ways.
        directed.push_back(task_word(1, 7'h04, 8, 30, 0, 2024, 5, 15, 3, 8, 30, 1));
        directed.push_back(task_word(2, 7'h04, 8, 30, 0, 2024, 5, 15, 3, 8, 30, 0));
        directed.push_back(task_word(3, 7'h04, 8, 30, 0, 2024, 5, 15, 3, 9, 0, 1));
        directed.push_back(task_word(4, 7'h04, 8, 29, 59, 2024, 5, 15, 3, 8, 30, 1));
        // Weekday zero: no match on the first day, scan resumes at Monday.
        directed.push_back(task_word(5, 7'h7F, 0, 0, 0, 2000, 1, 1, 0, 0, 0, 1));
        directed.push_back(task_word(3, 7'h40, 10, 0, 0, 2030, 8, 8, 0, 0, 0, 1));
        // Sunday wraps to Monday, everything at its top legal value.
        directed.push_back(task_word(6, 7'h01, 23, 59, 59, 2099, 12, 31, 7, 23, 59, 1));
        // Leap year either side of the leap day.
        directed.push_back(task_word(7, 7'h7F, 12, 0, 0, 1972, 2, 28, 2, 0, 0, 1));
        directed.push_back(task_word(8, 7'h7F, 12, 0, 0, 1972, 3, 1, 2, 0, 0, 1));
        // Month zero taken as January, months past twelve as December.
        directed.push_back(task_word(9, 7'h7F, 1, 2, 3, 2001, 0, 10, 4, 0, 0, 1));
        directed.push_back(task_word(10, 7'h7F, 1, 2, 3, 2004, 13, 10, 4, 0, 0, 1));
        directed.push_back(task_word(11, 7'h7F, 1, 2, 3, 2005, 15, 10, 4, 0, 0, 1));
        // Day zero, and a day sum running past the month.
        directed.push_back(task_word(12, 7'h7F, 0, 0, 0, 1970, 1, 0, 5, 0, 0, 1));
        directed.push_back(task_word(13, 7'h40, 0, 0, 0, 2050, 6, 31, 7, 1, 0, 0));
        // Years at and below the epoch, and the top of the field.
        directed.push_back(task_word(1, 7'h7F, 0, 0, 0, 1970, 1, 1, 4, 0, 0, 1));
        directed.push_back(task_word(14, 7'h7F, 0, 0, 0, 1969, 12, 31, 3, 0, 0, 1));
        directed.push_back(task_word(15, 7'h7F, 0, 0, 0, 0, 1, 1, 1, 0, 0, 1));
        directed.push_back(task_word(0, 7'h7F, 31, 63, 63, 4095, 15, 31, 7, 31, 63, 1));
        // Hour out of range makes today look passed.
        directed.push_back(task_word(2, 7'h7F, 0, 0, 0, 2020, 7, 4, 6, 31, 63, 1));
        // Same hour, later minute; all bits of slot and mask set.
        directed.push_back(task_word(15, 7'h7F, 6, 45, 30, 2016, 9, 9, 5, 6, 44, 1));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i])
            send_task(directed[i]);

        // Random words, with every third block run flat out on both sides.
        for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
            if (n % QUIET_BLOCK == 0)
                quiet = ((n / QUIET_BLOCK) % 3 == 1);
            send_task(random_task());
        end
        s_tvalid <= 1'b0;
        quiet = 1'b0;

        while (board.pending_alarms.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
